// ----- hw/rtl/page_frame_bitmap_allocator_core_macros.svh -----
// Assertion macros for the checker file of the page frame allocator.
// No dependencies; included by the checker module.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PFBA_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PFBA_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/pfba_pkg.sv -----
// Types and constants of the bitmap page frame allocator.
// No dependencies; used by the word unit, the core, the checker and the testbench.
package pfba_pkg;

  localparam int WORD_BITS   = 8;
  localparam int PG_W        = 21;
  localparam int WIDX_W      = PG_W - 3;
  localparam int CNT_W       = 13;
  localparam int ADDR_W      = 32;
  localparam int PAGE_SHIFT  = 12;
  localparam int CHG_W       = 4;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;
  localparam logic [CNT_W-1:0] MANAGED_RESET = 13'd4096;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_ALLOC = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] new_word;
    logic [CHG_W-1:0]     chg_cnt;
    logic [CNT_W-1:0]     run;
    logic                 hit;
    logic [PG_W-1:0]      first;
    logic                 at_end;
  } word_res_t;

endpackage

// ----- hw/rtl/pfba_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies; holds the allocation map words.
module pfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/pfba_word_unit.sv -----
// Shared word evaluator: run masking, bit update, changed-bit count and
// first-fit run tracking over one 8-page map word. Depends on pfba_pkg.
module pfba_word_unit (
  input  logic [pfba_pkg::WIDX_W-1:0]    word_idx,
  input  logic [pfba_pkg::WORD_BITS-1:0] rd_data,
  input  logic                           set_bits,
  input  logic [pfba_pkg::PG_W-1:0]      start_pg,
  input  logic [pfba_pkg::PG_W-1:0]      end_pg,
  input  logic [pfba_pkg::PG_W-1:0]      lim,
  input  logic [pfba_pkg::CNT_W-1:0]     run_in,
  input  logic [pfba_pkg::CNT_W-1:0]     need,
  output pfba_pkg::word_res_t            res
);
  import pfba_pkg::*;

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] in_lim;
  logic [WORD_BITS-1:0] changed;
  logic [CNT_W-1:0]     run;
  logic                 hit;
  logic [2:0]           hit_pos;
  logic [CHG_W-1:0]     chg;
  logic [PG_W-1:0]      next_base;

  // Per-page range tests are independent of each other.
  always_comb begin
    logic [PG_W-1:0] p;
    for (int j = 0; j < WORD_BITS; j++) begin
      p         = {word_idx, 3'(j)};
      mask[j]   = (p >= start_pg) && (p < end_pg);
      in_lim[j] = (p < lim);
    end
  end

  assign changed = set_bits ? (mask & ~rd_data) : (mask & rd_data);

  always_comb begin
    chg = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      chg = chg + CHG_W'(changed[j]);
    end
  end

  // Free-run counter carried across the word, stopping at the first fit.
  always_comb begin
    run     = run_in;
    hit     = 1'b0;
    hit_pos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (!hit && in_lim[j]) begin
        if (rd_data[j]) begin
          run = '0;
        end else begin
          run = run + 1'b1;
          if (run == need) begin
            hit     = 1'b1;
            hit_pos = 3'(j);
          end
        end
      end
    end
  end

  assign next_base = {word_idx, 3'b000} + PG_W'(WORD_BITS);

  always_comb begin
    res.new_word = set_bits ? (rd_data | mask) : (rd_data & ~mask);
    res.chg_cnt  = chg;
    res.run      = run;
    res.hit      = hit;
    res.first    = {word_idx, hit_pos} + PG_W'(1) - PG_W'(need);
    res.at_end   = (next_base >= lim);
  end

endmodule

// ----- hw/rtl/page_frame_bitmap_allocator_core.sv -----
// First-fit bitmap page frame allocator, one bit per page in a word RAM.
// An item is accepted in idle, reads each map word it needs and evaluates it, writing it
// back for mark/free: a query reads one word, mark/free each word touched, allocate each
// word scanned up to the fit, then each word marked; an item needing no word goes straight
// to done. The result becomes valid in the cycle ready returns, and an earlier result
// still unaccepted stalls the end. Synchronous reset first clears all ceil(MAX_PAGES/8) words.
module page_frame_bitmap_allocator_core #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [pfba_pkg::CNT_W-1:0]          cfg_wr_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: [31:0] page_addr, [44:32] page_count, [47:45] zero
  input  logic [pfba_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // tuser: [1:0] op
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: [0] found, [32:1] run_addr, [33] is_taken, [46:34] taken_count,
  // [47] zero
  output logic [pfba_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import pfba_pkg::*;

  localparam int NWORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = NWORDS > 1 ? $clog2(NWORDS) : 1;
  localparam int TW     = $clog2(MAX_PAGES + 1);
  localparam int TCW    = TW > CNT_W ? TW : CNT_W;
  localparam logic [PG_W-1:0] MAX_PG   = PG_W'(MAX_PAGES);
  localparam logic [AW-1:0]   LAST_ROW = AW'(NWORDS - 1);

  state_t state, state_next;

  logic [CNT_W-1:0]  managed;
  logic [TCW-1:0]    total;
  logic [AW-1:0]     clr_addr;
  op_t               op_r;
  logic [PG_W-1:0]   start_pg;
  logic [PG_W-1:0]   end_pg;
  logic [CNT_W-1:0]  need;
  logic [WIDX_W-1:0] wrd;
  logic [CNT_W-1:0]  run_r;
  logic              found_r;
  logic              taken_r;
  logic [PG_W-1:0]   first_r;

  logic              out_valid;
  logic              out_found;
  logic [ADDR_W-1:0] out_run_addr;
  logic              out_taken;
  logic [CNT_W-1:0]  out_count;

  logic [PG_W-1:0]   lim;
  logic [PG_W-1:0]   managed_ext;
  op_t               in_op;
  logic [CNT_W-1:0]  in_cnt;
  logic [PG_W-1:0]   in_start;
  logic [PG_W-1:0]   in_end_raw;
  logic [PG_W-1:0]   in_end;
  logic              in_quick;
  logic              accept;
  logic              out_free;
  logic [PG_W-1:0]   end_m1;
  logic              last_word;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;
  word_res_t            wres;

  assign managed_ext = PG_W'(managed);
  assign lim         = (managed_ext > MAX_PG) ? MAX_PG : managed_ext;

  assign in_op      = op_t'(s_axis_tuser);
  assign in_cnt     = s_axis_tdata[ADDR_W +: CNT_W];
  assign in_start   = PG_W'(s_axis_tdata[ADDR_W-1:PAGE_SHIFT]);
  assign in_end_raw = in_start + PG_W'(in_cnt);
  assign in_end     = (in_end_raw < lim) ? in_end_raw : lim;

  // Items that finish without touching the map.
  always_comb begin
    case (in_op)
      OP_MARK, OP_FREE: in_quick = (in_start >= in_end);
      OP_QUERY:         in_quick = (in_start >= lim);
      OP_ALLOC:         in_quick = (in_cnt == '0) || (PG_W'(in_cnt) > lim);
      default:          in_quick = 1'b1;
    endcase
  end

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid || m_axis_tready;
  assign end_m1    = end_pg - PG_W'(1);
  assign last_word = (wrd == end_m1[PG_W-1:3]);

  pfba_word_unit u_word (
    .word_idx (wrd),
    .rd_data  (ram_rdata),
    .set_bits (op_r == OP_MARK),
    .start_pg (start_pg),
    .end_pg   (end_pg),
    .lim      (lim),
    .run_in   (run_r),
    .need     (need),
    .res      (wres)
  );

  pfba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (wrd[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ROW) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = in_quick ? ST_DONE : ST_RD;
      end
      ST_RD: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        case (op_r)
          OP_QUERY: state_next = ST_DONE;
          OP_ALLOC: begin
            if (wres.hit) state_next = ST_RD;
            else if (wres.at_end) state_next = ST_DONE;
            else state_next = ST_RD;
          end
          default: state_next = last_word ? ST_DONE : ST_RD;
        endcase
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    ram_re        = (state == ST_RD);
    ram_we        = 1'b0;
    ram_waddr     = wrd[AW-1:0];
    ram_wdata     = wres.new_word;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_EVAL: begin
        ram_we = (op_r == OP_MARK) || (op_r == OP_FREE);
      end
      default: ram_we = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      managed   <= MANAGED_RESET;
      total     <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) managed <= cfg_wr_data;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == ST_EVAL) begin
        if (op_r == OP_MARK) total <= total + TCW'(wres.chg_cnt);
        else if (op_r == OP_FREE) total <= total - TCW'(wres.chg_cnt);
      end
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // Item registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      op_r     <= in_op;
      need     <= in_cnt;
      run_r    <= '0;
      found_r  <= 1'b0;
      first_r  <= '0;
      taken_r  <= (in_op == OP_QUERY) && (in_start >= lim);
      start_pg <= in_start;
      end_pg   <= in_end;
      wrd      <= (in_op == OP_ALLOC) ? '0 : in_start[PG_W-1:3];
    end else if (state == ST_EVAL) begin
      case (op_r)
        OP_QUERY: taken_r <= ram_rdata[start_pg[2:0]];
        OP_ALLOC: begin
          if (wres.hit) begin
            // The fit is known to be free and in range: mark it like a run.
            op_r     <= OP_MARK;
            found_r  <= 1'b1;
            first_r  <= wres.first;
            start_pg <= wres.first;
            end_pg   <= wres.first + PG_W'(need);
            wrd      <= wres.first[PG_W-1:3];
          end else begin
            run_r <= wres.run;
            wrd   <= wrd + 1'b1;
          end
        end
        default: wrd <= wrd + 1'b1;
      endcase
    end
    if (state == ST_DONE && out_free) begin
      out_found    <= found_r;
      out_run_addr <= found_r ? {first_r[ADDR_W-PAGE_SHIFT-1:0], PAGE_SHIFT'(0)} : '0;
      out_taken    <= taken_r;
      out_count    <= total[CNT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_count, out_taken, out_run_addr, out_found};

endmodule

// ----- hw/rtl/pfba_checker.sv -----
// Port-level checker for the page frame allocator, bound to the top level.
// Depends on pfba_pkg and page_frame_bitmap_allocator_core_macros.svh.
`include "page_frame_bitmap_allocator_core_macros.svh"

module pfba_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pfba_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import pfba_pkg::*;

  // A result item waiting on the sink keeps its value.
  `PFBA_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Once an item is taken the block is busy with it.
  `PFBA_ASSERT_NXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after an accepted item")

  // A query result and a successful allocation never come together.
  `PFBA_ASSERT_NOW(a_found_taken, clk, rst, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[33]), "found and is_taken both set")

  // A failed or non-allocating item reports a zero run address.
  `PFBA_ASSERT_NOW(a_addr_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[32:1] == '0, "run address without a fit")

  // Allocated runs start on a page boundary.
  `PFBA_ASSERT_NOW(a_page_align, clk, rst, m_axis_tvalid, m_axis_tdata[12:1] == '0, "run address not page aligned")

endmodule

bind page_frame_bitmap_allocator_core pfba_checker u_pfba_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- sim/page_frame_bitmap_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the first-fit page frame allocator core.
// It streams page requests, keeps its own copy of the page map and checks each reply.
// Depends on pfba_pkg and page_frame_bitmap_allocator_core.
module page_frame_bitmap_allocator_core_tb;
  import pfba_pkg::*;

  localparam int MAX_PAGES = 4096;
  // The reset clearing pass writes each map word in turn.
  localparam int CLEAR_CYCLES = MAX_PAGES / 8 + 16;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASE_ITEMS = 180;
  localparam int NUM_PHASES = 8;
  // The limit allows for the slowest items with stalls; there are about 1500 items.
  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
  } page_req_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] run_addr;
    logic              is_taken;
    logic [CNT_W-1:0]  taken_count;
  } page_reply_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]       cfg_wr_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: [31:0] page_addr, [44:32] page_count, [47:45] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // tuser: [1:0] op
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: [0] found, [32:1] run_addr, [33] is_taken, [46:34] taken_count, [47] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  page_req_t   pending_reqs[$];
  page_reply_t alloc_replies[$];

  // Local copy of the allocator state.
  bit               frame_map[MAX_PAGES];
  int unsigned      used_pages = 0;
  logic [CNT_W-1:0] managed_reg = MANAGED_RESET;

  int n_sent = 0;
  int n_checked = 0;
  int n_found = 0;
  int n_errors = 0;
  longint cycle_count = 0;

  page_frame_bitmap_allocator_core #(
    .MAX_PAGES(MAX_PAGES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned managed_limit();
    return (managed_reg > MAX_PAGES) ? MAX_PAGES : managed_reg;
  endfunction

  // Pages at or above the limit are left alone; the count follows real bit changes only.
  function automatic void set_frame(input int unsigned pg, input int unsigned lim,
                                    input bit value);
    if (pg < lim && frame_map[pg] != value) begin
      frame_map[pg] = value;
      if (value) used_pages++;
      else used_pages--;
    end
  endfunction

  function automatic page_reply_t apply_page_op(input page_req_t req);
    page_reply_t rep;
    int unsigned lim, start, run, first, p, i;
    bit hit;
    rep = '0;
    lim = managed_limit();
    start = req.addr >> PAGE_SHIFT;
    run = 0;
    first = 0;
    hit = 1'b0;
    case (req.op)
      OP_MARK: begin
        for (i = 0; i < req.count; i++) set_frame(start + i, lim, 1'b1);
      end
      OP_FREE: begin
        for (i = 0; i < req.count; i++) set_frame(start + i, lim, 1'b0);
      end
      OP_QUERY: begin
        if (start >= lim) rep.is_taken = 1'b1;
        else rep.is_taken = frame_map[start];
      end
      default: begin
        if (req.count != 0 && req.count <= lim) begin
          for (p = 0; p < lim && !hit; p++) begin
            if (frame_map[p]) begin
              run = 0;
            end else begin
              run++;
              if (run == req.count) begin
                first = p + 1 - req.count;
                hit = 1'b1;
              end
            end
          end
          if (hit) begin
            for (i = 0; i < req.count; i++) set_frame(first + i, lim, 1'b1);
            rep.found = 1'b1;
            rep.run_addr = first << PAGE_SHIFT;
          end
        end
      end
    endcase
    rep.taken_count = used_pages[CNT_W-1:0];
    return rep;
  endfunction

  // Byte address inside the given page, with a random offset.
  function automatic logic [ADDR_W-1:0] to_addr(input int unsigned pg);
    return (pg << PAGE_SHIFT) | $urandom_range(0, 4095);
  endfunction

  task automatic push_req(input op_t op, input logic [ADDR_W-1:0] addr,
                          input logic [CNT_W-1:0] count);
    page_req_t req;
    req.op = op;
    req.addr = addr;
    req.count = count;
    pending_reqs.push_back(req);
  endtask

  task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    n_errors++;
  endtask

  task automatic write_managed(input logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    managed_reg = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_axis_tvalid || alloc_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_directed();
    push_req(OP_QUERY, to_addr(0), '0);
    push_req(OP_ALLOC, '0, '0);
    push_req(OP_ALLOC, '0, CNT_W'(4097));
    push_req(OP_ALLOC, '0, CNT_W'(8191));
    push_req(OP_ALLOC, 32'hFFFF_FFFF, CNT_W'(1));
    push_req(OP_MARK, to_addr(5), CNT_W'(3));
    // Pages that are already set stay set and the count does not move.
    push_req(OP_MARK, to_addr(5), CNT_W'(2));
    push_req(OP_FREE, to_addr(256), CNT_W'(1));
    push_req(OP_MARK, to_addr(10), '0);
    push_req(OP_FREE, to_addr(5), '0);
    // A run that crosses the top of the managed range is cut off there.
    push_req(OP_MARK, to_addr(4094), CNT_W'(5));
    push_req(OP_QUERY, to_addr(4095), '0);
    push_req(OP_QUERY, to_addr(4096), '0);
    push_req(OP_QUERY, 32'hFFFF_FFFF, '0);
    push_req(OP_MARK, 32'hFFFF_F000, CNT_W'(8191));
    push_req(OP_ALLOC, '0, CNT_W'(4));
    push_req(OP_ALLOC, '0, CNT_W'(4096));
    push_req(OP_FREE, 32'h0000_0000, CNT_W'(8191));
    push_req(OP_ALLOC, '0, CNT_W'(4096));
    push_req(OP_QUERY, to_addr(100), '0);
    push_req(OP_FREE, 32'h0000_0FFF, CNT_W'(4096));
    push_req(OP_QUERY, 32'h0000_0FFF, CNT_W'(8191));
  endtask

  task automatic queue_random(input int n_items);
    int unsigned lim, pg, cnt, pick;
    int made;
    op_t op;
    lim = managed_limit();
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 49) == 0 && lim > 0) begin
        // Release the whole map now and then so allocation keeps finding room.
        push_req(OP_FREE, '0, CNT_W'(lim));
        made++;
      end else if ($urandom_range(0, 9) < 4) begin
        // Mark a run, probe both ends, free it and probe the start again.
        pg = $urandom_range(0, lim + 2);
        cnt = $urandom_range(1, 12);
        push_req(OP_MARK, to_addr(pg), CNT_W'(cnt));
        push_req(OP_QUERY, to_addr(pg), CNT_W'($urandom_range(0, 8191)));
        push_req(OP_QUERY, to_addr(pg + cnt - 1), '0);
        push_req(OP_FREE, to_addr(pg), CNT_W'(cnt));
        push_req(OP_QUERY, to_addr(pg), '0);
        made += 5;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 7) op = OP_ALLOC;
        else if (pick < 12) op = OP_FREE;
        else if (pick < 15) op = OP_MARK;
        else op = OP_QUERY;
        pick = $urandom_range(0, 99);
        if (pick < 4) cnt = 0;
        else if (pick < 90) cnt = $urandom_range(1, 16);
        else if (pick < 97) cnt = $urandom_range(1, lim + 2);
        else cnt = $urandom_range(0, 8191);
        if ($urandom_range(0, 99) < 15) push_req(op, $urandom(), CNT_W'(cnt));
        else push_req(op, to_addr($urandom_range(0, lim + 8)), CNT_W'(cnt));
        made++;
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps, some of them empty.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin : drive_requests
    page_req_t next_req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, next_req.count, next_req.addr};
        s_axis_tuser <= next_req.op;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: ready runs of random length, each followed by a stall or none.
  int stall_left = 0;
  int ready_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (ready_left > 0) begin
      m_axis_tready <= 1'b1;
      ready_left <= ready_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      ready_left <= $urandom_range(0, 30);
      stall_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
    end
  end

  // Checks replies first, then predicts the reply of a request accepted at this edge.
  always @(posedge clk) begin : check_replies
    page_reply_t got, want;
    page_req_t   req;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found = m_axis_tdata[0];
        got.run_addr = m_axis_tdata[32:1];
        got.is_taken = m_axis_tdata[33];
        got.taken_count = m_axis_tdata[46:34];
        if (alloc_replies.size() == 0) begin
          $display("%0t: reply with no request pending, expected none, actual %h",
                   $time, m_axis_tdata);
          n_errors++;
        end else begin
          want = alloc_replies.pop_front();
          n_checked++;
          if (got.found !== want.found)
            report_mismatch("found", ADDR_W'(want.found), ADDR_W'(got.found));
          if (got.run_addr !== want.run_addr)
            report_mismatch("run_addr", want.run_addr, got.run_addr);
          if (got.is_taken !== want.is_taken)
            report_mismatch("is_taken", ADDR_W'(want.is_taken), ADDR_W'(got.is_taken));
          if (got.taken_count !== want.taken_count)
            report_mismatch("taken_count", ADDR_W'(want.taken_count),
                            ADDR_W'(got.taken_count));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.op = op_t'(s_axis_tuser);
        req.addr = s_axis_tdata[31:0];
        req.count = s_axis_tdata[44:32];
        want = apply_page_op(req);
        if (want.found) n_found++;
        alloc_replies.push_back(want);
        n_sent++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles with %0d replies outstanding",
               $time, cycle_count, alloc_replies.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : run_phases
    int unsigned phase_limits[NUM_PHASES];
    int ph;
    // Full range, saturation, empty range, then growing again step by step.
    phase_limits = '{4096, 8191, 0, 1, 8, 37, 300, 4096};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (CLEAR_CYCLES) @(posedge clk);
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_managed(CNT_W'(phase_limits[ph]));
      if (ph == 0) queue_directed();
      queue_random(PHASE_ITEMS);
      wait_drained();
    end
    $display("Sent %0d page requests across %0d managed-page settings (0 to 8191).",
             n_sent, NUM_PHASES);
    $display("Checked %0d replies, %0d of them successful allocations.", n_checked, n_found);
    if (n_errors == 0 && alloc_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/pfba_pkg.sv
hw/rtl/pfba_ram.sv
hw/rtl/pfba_word_unit.sv
hw/rtl/page_frame_bitmap_allocator_core.sv
hw/rtl/pfba_checker.sv
sim/page_frame_bitmap_allocator_core_tb.sv
